[rtl/bgd_pkg.sv]
// Package for the button gesture detector: shared types, codes and reset values.
package bgd_pkg;

    // Configuration register width and reset values
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int TIMER_BITS_DEF   = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd750;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RST       = 16'd100;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_LONG_PRESS   = 2'd1,
        REG_DOUBLE_CLICK = 2'd2,
        REG_REPEAT       = 2'd3
    } reg_idx_t;

    // Click report codes
    localparam logic [1:0] CLICK_NONE   = 2'd0;
    localparam logic [1:0] CLICK_SINGLE = 2'd1;
    localparam logic [1:0] CLICK_DOUBLE = 2'd2;

    // Click tally values
    localparam logic [1:0] TALLY_ZERO = 2'd0;
    localparam logic [1:0] TALLY_ONE  = 2'd1;
    localparam logic [1:0] TALLY_TWO  = 2'd2;
    localparam logic [1:0] TALLY_MAX  = 2'd3;

    // Timing thresholds
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] double_click_ms;
        logic [CFG_W-1:0] repeat_ms;
    } cfg_t;

    // Single-bit and tally state of the gesture tracker
    typedef struct packed {
        logic       raw_previous;
        logic       stable_level;
        logic       long_active;
        logic [1:0] click_tally;
    } flags_t;

    // One result item
    typedef struct packed {
        logic       button_stable;
        logic [1:0] click_event;
        logic       long_press_start;
        logic       repeat_action;
    } result_t;

endpackage

[rtl/bgd_core.sv]
// Per-tick next-state and result logic of the button gesture detector.
module bgd_core #(
    parameter int TIMER_BITS = bgd_pkg::TIMER_BITS_DEF
) (
    input  logic                  button_raw,
    input  bgd_pkg::cfg_t         cfg,
    input  bgd_pkg::flags_t       flags,
    input  logic [TIMER_BITS-1:0] since_level_change,
    input  logic [TIMER_BITS-1:0] since_press,
    input  logic [TIMER_BITS-1:0] since_repeat,
    output bgd_pkg::flags_t       flags_next,
    output logic [TIMER_BITS-1:0] since_level_change_next,
    output logic [TIMER_BITS-1:0] since_press_next,
    output logic [TIMER_BITS-1:0] since_repeat_next,
    output bgd_pkg::result_t      result
);

    // Compare width covers both timer and register
    localparam int CMP_W = (TIMER_BITS > bgd_pkg::CFG_W) ? TIMER_BITS : bgd_pkg::CFG_W;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (&t) ? t : t + TIMER_BITS'(1);
    endfunction

    function automatic logic gt(input logic [TIMER_BITS-1:0] t,
                                input logic [bgd_pkg::CFG_W-1:0] r);
        return CMP_W'(t) > CMP_W'(r);
    endfunction

    always_comb begin
        bgd_pkg::flags_t       f;
        logic [TIMER_BITS-1:0] slc;
        logic [TIMER_BITS-1:0] sp;
        logic [TIMER_BITS-1:0] sr;
        logic [1:0]            click;
        logic                  lp_start;
        logic                  rep;

        f        = flags;
        click    = bgd_pkg::CLICK_NONE;
        lp_start = 1'b0;
        rep      = 1'b0;

        // Elapsed-time counters advance and saturate
        slc = sat_inc(since_level_change);
        sp  = sat_inc(since_press);
        sr  = sat_inc(since_repeat);

        // Raw level change restarts debounce
        if (button_raw != flags.raw_previous) begin
            slc = '0;
        end

        // Debounced level update, press counting
        if (gt(slc, cfg.debounce_ms) && (button_raw != f.stable_level)) begin
            f.stable_level = button_raw;
            f.long_active  = 1'b0;
            if (button_raw) begin
                sp = '0;
                if (f.click_tally != bgd_pkg::TALLY_MAX) begin
                    f.click_tally = f.click_tally + 2'd1;
                end
            end
        end
        f.raw_previous = button_raw;

        // Long press start cancels pending clicks
        if (f.stable_level && !f.long_active && gt(sp, cfg.long_press_ms)) begin
            f.long_active = 1'b1;
            f.click_tally = bgd_pkg::TALLY_ZERO;
            lp_start      = 1'b1;
        end

        // Repeat action during long press
        if (f.long_active && gt(sr, cfg.repeat_ms)) begin
            sr  = '0;
            rep = 1'b1;
        end

        // Click report after release and double-click window
        if ((f.click_tally != bgd_pkg::TALLY_ZERO) && !f.stable_level &&
            gt(sp, cfg.double_click_ms)) begin
            case (f.click_tally)
                bgd_pkg::TALLY_ONE: click = bgd_pkg::CLICK_SINGLE;
                bgd_pkg::TALLY_TWO: click = bgd_pkg::CLICK_DOUBLE;
                default:            click = bgd_pkg::CLICK_NONE;
            endcase
            f.click_tally = bgd_pkg::TALLY_ZERO;
        end

        flags_next              = f;
        since_level_change_next = slc;
        since_press_next        = sp;
        since_repeat_next       = sr;
        result.button_stable    = f.stable_level;
        result.click_event      = click;
        result.long_press_start = lp_start;
        result.repeat_action    = rep;
    end

endmodule

[rtl/button_gesture_detector.sv]
// Top level of the button gesture detector: configuration, input, state and result registers.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   s_      | in        | s_valid / s_ready    | s_button_raw
//   m_      | out       | m_valid / m_ready    | m_button_stable, m_click_event,
//           |           |                      | m_long_press_start, m_repeat_action
//   cfg_    | in        | cfg_wr_en            | cfg_index, cfg_wdata
//
// One request per cycle sustained while m_ready stays high. A request accepted sits in the
// input register, is processed into the result register, and can be taken from there
// when the output is not stalled.
// The tick update is one pass of compare and saturating-increment logic.
// aresetn (synchronous, active low) clears state, timers to saturated, and the
// thresholds to their defaults. A stalled m_ready holds the result; an empty input
// register takes one more request, then s_ready drops until the result is taken.
module button_gesture_detector #(
    parameter int TIMER_BITS = bgd_pkg::TIMER_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgd_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_button_raw,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_button_stable,
    output logic [1:0]                   m_click_event,
    output logic                         m_long_press_start,
    output logic                         m_repeat_action
);

    bgd_pkg::cfg_t         cfg_reg;
    bgd_pkg::flags_t       flags_reg, flags_next;
    logic [TIMER_BITS-1:0] slc_reg, slc_next;
    logic [TIMER_BITS-1:0] sp_reg, sp_next;
    logic [TIMER_BITS-1:0] sr_reg, sr_next;
    logic                  in_valid_reg;
    logic                  in_raw_reg;
    logic                  out_valid_reg;
    bgd_pkg::result_t      out_reg, out_next;
    logic                  advance;

    // Tick moves from input register into result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms     <= bgd_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ms   <= bgd_pkg::LONG_PRESS_RST;
            cfg_reg.double_click_ms <= bgd_pkg::DOUBLE_CLICK_RST;
            cfg_reg.repeat_ms       <= bgd_pkg::REPEAT_RST;
        end else if (cfg_wr_en) begin
            unique case (bgd_pkg::reg_idx_t'(cfg_index))
                bgd_pkg::REG_DEBOUNCE:     cfg_reg.debounce_ms     <= cfg_wdata;
                bgd_pkg::REG_LONG_PRESS:   cfg_reg.long_press_ms   <= cfg_wdata;
                bgd_pkg::REG_DOUBLE_CLICK: cfg_reg.double_click_ms <= cfg_wdata;
                bgd_pkg::REG_REPEAT:       cfg_reg.repeat_ms       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_raw_reg <= s_button_raw;
        end
    end

    // Tick logic
    bgd_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .button_raw              (in_raw_reg),
        .cfg                     (cfg_reg),
        .flags                   (flags_reg),
        .since_level_change      (slc_reg),
        .since_press             (sp_reg),
        .since_repeat            (sr_reg),
        .flags_next              (flags_next),
        .since_level_change_next (slc_next),
        .since_press_next        (sp_next),
        .since_repeat_next       (sr_next),
        .result                  (out_next)
    );

    // Gesture state, updated once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            slc_reg   <= '1;
            sp_reg    <= '1;
            sr_reg    <= '1;
        end else if (advance) begin
            flags_reg <= flags_next;
            slc_reg   <= slc_next;
            sp_reg    <= sp_next;
            sr_reg    <= sr_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_button_stable    = out_reg.button_stable;
    assign m_click_event      = out_reg.click_event;
    assign m_long_press_start = out_reg.long_press_start;
    assign m_repeat_action    = out_reg.repeat_action;

endmodule

[verif/button_gesture_detector_tb.sv]
// Self-checking testbench for the button gesture detector: debounce, clicks and long press.
module button_gesture_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TMR_W = bgd_pkg::TIMER_BITS_DEF;
    localparam logic [TMR_W-1:0] TMR_SAT = {TMR_W{1'b1}};
    localparam logic [bgd_pkg::CFG_W-1:0] CFG_MAX = {bgd_pkg::CFG_W{1'b1}};
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TICK_TARGET   = 2000;

    // DUT ports
    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    bgd_pkg::reg_idx_t         cfg_index = bgd_pkg::REG_DEBOUNCE;
    logic [bgd_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_button_raw = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_button_stable;
    logic [1:0]                m_click_event;
    logic                      m_long_press_start;
    logic                      m_repeat_action;

    // Gesture model state
    bgd_pkg::cfg_t    cfg_model;
    logic             mdl_raw_prev;
    logic             mdl_stable;
    logic             mdl_long;
    logic [1:0]       mdl_tally;
    logic [TMR_W-1:0] since_change;
    logic [TMR_W-1:0] since_press;
    logic [TMR_W-1:0] since_repeat;

    bgd_pkg::result_t pending_results[$];

    // Run control and statistics
    int   s_idle_pct = 20;
    int   m_idle_pct = 20;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   mismatch_count = 0;
    int   ticks_sent = 0;
    int   results_checked = 0;
    int   settings_used = 0;
    int   n_single = 0;
    int   n_double = 0;
    int   n_long = 0;
    int   n_repeat = 0;

    button_gesture_detector #(
        .TIMER_BITS(TMR_W)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_button_raw      (s_button_raw),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_button_stable   (m_button_stable),
        .m_click_event     (m_click_event),
        .m_long_press_start(m_long_press_start),
        .m_repeat_action   (m_repeat_action)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [TMR_W-1:0] sat_inc(input logic [TMR_W-1:0] t);
        return (t == TMR_SAT) ? TMR_SAT : t + 1'b1;
    endfunction

    function automatic void model_reset();
        cfg_model    = '{bgd_pkg::DEBOUNCE_RST, bgd_pkg::LONG_PRESS_RST,
                         bgd_pkg::DOUBLE_CLICK_RST, bgd_pkg::REPEAT_RST};
        mdl_raw_prev = 1'b0;
        mdl_stable   = 1'b0;
        mdl_long     = 1'b0;
        mdl_tally    = bgd_pkg::TALLY_ZERO;
        since_change = TMR_SAT;
        since_press  = TMR_SAT;
        since_repeat = TMR_SAT;
    endfunction

    // One millisecond tick of the gesture tracker
    function automatic bgd_pkg::result_t gesture_step(input logic raw);
        bgd_pkg::result_t r;
        r = '0;
        since_change = sat_inc(since_change);
        since_press  = sat_inc(since_press);
        since_repeat = sat_inc(since_repeat);

        if (raw != mdl_raw_prev) since_change = '0;

        // debounce and press handling
        if (since_change > cfg_model.debounce_ms && raw != mdl_stable) begin
            mdl_stable = raw;
            mdl_long   = 1'b0;
            if (mdl_stable) begin
                since_press = '0;
                if (mdl_tally != bgd_pkg::TALLY_MAX) mdl_tally = mdl_tally + 1'b1;
            end
        end
        mdl_raw_prev = raw;

        if (mdl_stable && !mdl_long && since_press > cfg_model.long_press_ms) begin
            mdl_long           = 1'b1;
            mdl_tally          = bgd_pkg::TALLY_ZERO;
            r.long_press_start = 1'b1;
        end

        if (mdl_long && since_repeat > cfg_model.repeat_ms) begin
            since_repeat    = '0;
            r.repeat_action = 1'b1;
        end

        // click report once the double-click window has closed
        if (mdl_tally != bgd_pkg::TALLY_ZERO && !mdl_stable &&
            since_press > cfg_model.double_click_ms) begin
            if (mdl_tally == bgd_pkg::TALLY_ONE)      r.click_event = bgd_pkg::CLICK_SINGLE;
            else if (mdl_tally == bgd_pkg::TALLY_TWO) r.click_event = bgd_pkg::CLICK_DOUBLE;
            else                                      r.click_event = bgd_pkg::CLICK_NONE;
            mdl_tally = bgd_pkg::TALLY_ZERO;
        end

        r.button_stable = mdl_stable;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [1:0] want,
                                          input logic [1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker
    always @(posedge aclk) begin
        bgd_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no pending tick, expected none, actual %b%b%b%b",
                         $time, m_button_stable, m_click_event, m_long_press_start,
                         m_repeat_action);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("button_stable", {1'b0, want.button_stable},
                              {1'b0, m_button_stable});
                compare_field("click_event", want.click_event, m_click_event);
                compare_field("long_press_start", {1'b0, want.long_press_start},
                              {1'b0, m_long_press_start});
                compare_field("repeat_action", {1'b0, want.repeat_action},
                              {1'b0, m_repeat_action});
                results_checked++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    // Watchdog on cycles with no request moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: timeout, no request moved for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one tick and wait for it to be taken
    task automatic send_tick(input logic raw);
        bgd_pkg::result_t r;
        while (s_idle_pct != 0 && $urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_button_raw <= raw;
        do @(posedge aclk); while (!s_ready);
        r = gesture_step(raw);
        pending_results.push_back(r);
        ticks_sent++;
        if (r.click_event == bgd_pkg::CLICK_SINGLE) n_single++;
        if (r.click_event == bgd_pkg::CLICK_DOUBLE) n_double++;
        if (r.long_press_start) n_long++;
        if (r.repeat_action) n_repeat++;
    endtask

    // Hold a level for n ticks, optionally after a short contact bounce
    task automatic send_level(input logic level, input int n, input bit bouncy);
        int bounces;
        bounces = (bouncy && $urandom_range(0, 1) != 0) ? $urandom_range(1, 3) : 0;
        repeat (bounces) send_tick(1'($urandom_range(0, 1)));
        repeat (n) send_tick(level);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [bgd_pkg::CFG_W-1:0] deb,
                              input logic [bgd_pkg::CFG_W-1:0] lp,
                              input logic [bgd_pkg::CFG_W-1:0] dc,
                              input logic [bgd_pkg::CFG_W-1:0] rp);
        bgd_pkg::reg_idx_t         order[4] = '{bgd_pkg::REG_DEBOUNCE, bgd_pkg::REG_LONG_PRESS,
                                                bgd_pkg::REG_DOUBLE_CLICK, bgd_pkg::REG_REPEAT};
        logic [bgd_pkg::CFG_W-1:0] vals[4];
        vals = '{deb, lp, dc, rp};
        settle();
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            case (order[i])
                bgd_pkg::REG_DEBOUNCE:     cfg_model.debounce_ms     = vals[i];
                bgd_pkg::REG_LONG_PRESS:   cfg_model.long_press_ms   = vals[i];
                bgd_pkg::REG_DOUBLE_CLICK: cfg_model.double_click_ms = vals[i];
                bgd_pkg::REG_REPEAT:       cfg_model.repeat_ms       = vals[i];
                default: ;
            endcase
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // One random gesture sized to the current thresholds
    task automatic send_gesture();
        int deb, lp, dc, rp, kind, clicks;
        deb  = int'(cfg_model.debounce_ms);
        lp   = int'(cfg_model.long_press_ms);
        dc   = int'(cfg_model.double_click_ms);
        rp   = int'(cfg_model.repeat_ms);
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            // one to three clicks, then a release past the window
            clicks = $urandom_range(1, 3);
            repeat (clicks) begin
                send_level(1'b1, deb + 1 + $urandom_range(0, lp), 1'b1);
                send_level(1'b0, deb + 1 + $urandom_range(0, dc), 1'b1);
            end
            send_level(1'b0, deb + dc + $urandom_range(2, 8), 1'b1);
        end else if (kind <= 6) begin
            // long press, with repeats when held long enough
            send_level(1'b1, deb + lp + $urandom_range(1, 3 * rp + 6), 1'b1);
            send_level(1'b0, deb + $urandom_range(1, dc + 6), 1'b1);
        end else if (kind == 7) begin
            // glitch around the debounce time
            send_level(1'b1, $urandom_range(0, deb + 2), 1'b0);
            send_level(1'b0, $urandom_range(1, deb + 3), 1'b0);
        end else begin
            repeat ($urandom_range(1, 16)) send_tick(1'($urandom_range(0, 1)));
        end
    endtask

    // Reset thresholds: press and release well past the default debounce
    task automatic test_defaults();
        send_level(1'b0, 3, 1'b0);
        send_level(1'b1, 60, 1'b1);
        send_level(1'b0, 60, 1'b1);
    endtask

    // Single, double and triple click; a triple is dropped silently
    task automatic test_clicks();
        set_config(16'd0, 16'd4, 16'd3, 16'd1);
        send_level(1'b1, 2, 1'b0);
        send_level(1'b0, 4, 1'b0);
        repeat (2) begin
            send_level(1'b1, 2, 1'b0);
            send_level(1'b0, 2, 1'b0);
        end
        send_level(1'b0, 2, 1'b0);
        repeat (3) begin
            send_level(1'b1, 2, 1'b0);
            send_level(1'b0, 2, 1'b0);
        end
        send_level(1'b0, 2, 1'b0);
    endtask

    // Long press, release ends it, second press within the repeat interval
    task automatic test_long_press();
        set_config(16'd0, 16'd2, 16'd3, 16'd8);
        send_level(1'b1, 6, 1'b0);
        send_level(1'b0, 2, 1'b0);
        send_level(1'b1, 6, 1'b0);
        send_level(1'b0, 3, 1'b0);
    endtask

    // Thresholds at the top (never passed) and at zero
    task automatic test_thresholds();
        set_config(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
        send_level(1'b1, 20, 1'b1);
        send_level(1'b0, 10, 1'b1);
        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        repeat (12) send_tick(1'($urandom_range(0, 1)));
        send_level(1'b1, 5, 1'b0);
        send_level(1'b0, 5, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering ticks
    task automatic test_backpressure();
        set_config(16'd2, 16'd10, 16'd6, 16'd3);
        s_idle_pct = 0;
        hold_req   = 1'b1;
        repeat (6) send_gesture();
        s_idle_pct = 20;
    endtask

    // Random thresholds per phase, gestures with random content
    task automatic test_random();
        int phase;
        phase = 0;
        while (ticks_sent < TICK_TARGET) begin
            set_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 40)),
                       16'($urandom_range(0, 30)), 16'($urandom_range(0, 12)));
            if (phase == 1) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end else begin
                s_idle_pct = 20;
                m_idle_pct = 20;
            end
            repeat ($urandom_range(4, 10)) begin
                if (ticks_sent < TICK_TARGET) send_gesture();
            end
            phase++;
        end
        s_idle_pct = 20;
        m_idle_pct = 20;
    endtask

    initial begin
        model_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_clicks();
        test_long_press();
        test_thresholds();
        test_backpressure();
        test_random();

        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Summary: %0d ticks over %0d threshold settings, %0d results checked",
                 ticks_sent, settings_used, results_checked);
        $display("Summary: %0d single, %0d double, %0d long press starts, %0d repeats",
                 n_single, n_double, n_long, n_repeat);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[button_gesture_detector.f]
rtl/bgd_pkg.sv
rtl/bgd_core.sv
rtl/button_gesture_detector.sv
verif/button_gesture_detector_tb.sv
